// ===== sv/mstqf_pkg.sv =====
package mstqf_pkg;

  localparam int MAX_VERTICES = 1023;
  localparam int LABEL_DEPTH  = MAX_VERTICES + 1;
  localparam int AW           = $clog2(LABEL_DEPTH);
  localparam int VW           = 10;
  localparam int CNTW         = 10;
  localparam int WW           = 31;
  localparam int UPC_W        = 4;

  localparam logic [CNTW-1:0] COUNT_MAX = '1;
  localparam logic [AW-1:0]   ADDR_LAST = AW'(LABEL_DEPTH - 1);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // microprogram step addresses
  localparam logic [UPC_W-1:0] UC_RST_INIT = UPC_W'(0);
  localparam logic [UPC_W-1:0] UC_IDLE     = UPC_W'(1);
  localparam logic [UPC_W-1:0] UC_CHECK    = UPC_W'(2);
  localparam logic [UPC_W-1:0] UC_RDTO     = UPC_W'(3);
  localparam logic [UPC_W-1:0] UC_CMP      = UPC_W'(4);
  localparam logic [UPC_W-1:0] UC_SWEEP0   = UPC_W'(5);
  localparam logic [UPC_W-1:0] UC_SWEEP    = UPC_W'(6);
  localparam logic [UPC_W-1:0] UC_TAIL     = UPC_W'(7);
  localparam logic [UPC_W-1:0] UC_INIT     = UPC_W'(8);
  localparam logic [UPC_W-1:0] UC_EMIT     = UPC_W'(9);

  typedef enum logic [1:0] {
    RD_ADDR = 2'd0,
    RD_FROM = 2'd1,
    RD_TO   = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_INIT  = 2'd1,
    WR_SWEEP = 2'd2
  } wr_sel_t;

  typedef enum logic [2:0] {
    C_SEQ      = 3'd0,
    C_GOTO     = 3'd1,
    C_LOOP     = 3'd2,
    C_WAIT_IN  = 3'd3,
    C_BAD      = 3'd4,
    C_SAME     = 3'd5,
    C_WAIT_OUT = 3'd6
  } cond_t;

  typedef struct packed {
    logic             in_rdy;
    logic             ld_item;
    rd_sel_t          rd;
    wr_sel_t          wr;
    logic             addr_inc;
    logic             cnt_clr;
    logic             cap_first;
    logic             try_accept;
    logic             out_load;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic new_graph;
    logic bad;
    logic same;
    logic addr_last;
    logic out_free;
  } stat_t;

  function automatic ctrl_t ucode(input logic [UPC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    c.rd = RD_ADDR;
    c.wr = WR_NONE;
    c.cond = C_SEQ;
    case (pc)
      UC_RST_INIT: begin
        c.wr = WR_INIT; c.addr_inc = 1'b1; c.cnt_clr = 1'b1;
        c.cond = C_LOOP; c.target = UC_IDLE;
      end
      UC_IDLE: begin
        c.in_rdy = 1'b1; c.ld_item = 1'b1;
        c.cond = C_WAIT_IN; c.target = UC_INIT;
      end
      UC_CHECK: begin
        c.rd = RD_FROM; c.cond = C_BAD; c.target = UC_EMIT;
      end
      UC_RDTO: begin
        c.rd = RD_TO; c.cap_first = 1'b1; c.cond = C_SEQ;
      end
      UC_CMP: begin
        c.try_accept = 1'b1; c.cond = C_SAME; c.target = UC_EMIT;
      end
      UC_SWEEP0: begin
        c.addr_inc = 1'b1; c.cond = C_SEQ;
      end
      UC_SWEEP: begin
        c.wr = WR_SWEEP; c.addr_inc = 1'b1;
        c.cond = C_LOOP; c.target = UC_TAIL;
      end
      UC_TAIL: begin
        c.wr = WR_SWEEP; c.cond = C_GOTO; c.target = UC_EMIT;
      end
      UC_INIT: begin
        c.wr = WR_INIT; c.addr_inc = 1'b1; c.cnt_clr = 1'b1;
        c.cond = C_LOOP; c.target = UC_CHECK;
      end
      UC_EMIT: begin
        c.out_load = 1'b1; c.cond = C_WAIT_OUT; c.target = UC_IDLE;
      end
      default: begin
        c.cond = C_GOTO; c.target = UC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== sv/mstqf_ifs.sv =====
interface mstqf_in_if import mstqf_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          new_graph;
  logic [VW-1:0] from_vertex;
  logic [VW-1:0] to_vertex;
  logic [WW-1:0] edge_length;
  logic          last_edge;

  modport source(output valid, new_graph, from_vertex, to_vertex, edge_length, last_edge,
                 input ready);
  modport sink(input valid, new_graph, from_vertex, to_vertex, edge_length, last_edge,
               output ready);
endinterface

interface mstqf_out_if import mstqf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            accepted;
  logic            status;
  logic [VW-1:0]   edge_from;
  logic [VW-1:0]   edge_to;
  logic [WW-1:0]   edge_weight;
  logic [CNTW-1:0] tree_edges;
  logic            spanning_done;
  logic            final_edge;

  modport source(output valid, accepted, status, edge_from, edge_to, edge_weight,
                 tree_edges, spanning_done, final_edge, input ready);
  modport sink(input valid, accepted, status, edge_from, edge_to, edge_weight,
               tree_edges, spanning_done, final_edge, output ready);
endinterface

interface mstqf_cfg_if import mstqf_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [VW-1:0] vertex_count;

  modport source(output valid, vertex_count, input ready);
  modport sink(input valid, vertex_count, output ready);
endinterface

// ===== sv/mst_edge_acceptor_quick_find_unit.sv =====
// Kruskal edge acceptor with a quick-find component label table.
// in_if (sink): one edge word per handshake (valid & ready), edges sorted by
// ascending length upstream. new_graph restarts labels and the tree count.
// out_if (source): exactly one result word per edge, in order.
// cfg_if (sink): vertex_count, always ready; write it only while idle.
// Steps per edge, from the input handshake to out_if.valid:
//   bad endpoint             check, emit
//   edge inside a component  check, read to, compare, emit
//   accepted edge            check, read to, compare, relabel sweep, emit
//   new_graph adds a label re-init pass; both passes cover all 1024 labels.
// Edges are processed one at a time: the next edge is taken only after the
// previous result has been loaded into the output register.
// The label table is a single 1024-entry RAM with one read and one write port;
// the sweep reads one label and writes one label per cycle, which sets the rate.
// in_if.ready is high only while the sequencer waits in its idle step, which is
// reached as soon as the result is loaded into the output register, so the next
// edge is accepted while the previous result still waits.
// Reset: an init pass writes label[i] = i for all 1024 labels and clears the
// count; no edge is accepted during it. A stalled receiver holds the result
// register and the sequencer waits before loading the next result.
module mst_edge_acceptor_quick_find_unit import mstqf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mstqf_in_if.sink    in_if,
  mstqf_out_if.source out_if,
  mstqf_cfg_if.sink   cfg_if
);

  ctrl_t            ctl;
  stat_t            st;
  logic [UPC_W-1:0] upc;

  logic [VW-1:0]   vcount_r;
  logic [VW-1:0]   from_r;
  logic [VW-1:0]   to_r;
  logic [WW-1:0]   len_r;
  logic            last_r;
  logic [AW-1:0]   first_r;
  logic [AW-1:0]   second_r;
  logic            acc_r;
  logic [CNTW-1:0] count_r;
  logic [AW-1:0]   addr_r;

  logic            out_valid_r;
  logic            out_acc_r;
  logic            out_status_r;
  logic [VW-1:0]   out_from_r;
  logic [VW-1:0]   out_to_r;
  logic [WW-1:0]   out_len_r;
  logic [CNTW-1:0] out_cnt_r;
  logic            out_done_r;
  logic            out_last_r;

  logic [VW-1:0]   nv;
  logic            bad;
  logic            in_fire;
  logic            out_free;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [AW-1:0]   mem_rdata;
  logic            same;
  logic            done;

  mstqf_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl),
    .upc   (upc)
  );

  mstqf_label_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign nv       = (int'(vcount_r) > MAX_VERTICES) ? VW'(MAX_VERTICES) : vcount_r;
  assign bad      = (from_r == '0) || (from_r > nv) || (to_r == '0) || (to_r > nv);
  assign in_fire  = in_if.valid && ctl.in_rdy;
  assign out_free = !out_valid_r || out_if.ready;
  assign same     = (mem_rdata == first_r);
  assign done     = ({1'b0, count_r} + 1'b1) >= {1'b0, nv};

  assign st.in_valid  = in_if.valid;
  assign st.new_graph = in_if.new_graph;
  assign st.bad       = bad;
  assign st.same      = same;
  assign st.addr_last = (addr_r == ADDR_LAST);
  assign st.out_free  = out_free;

  always_comb begin
    case (ctl.rd)
      RD_FROM: mem_raddr = AW'(from_r);
      RD_TO:   mem_raddr = AW'(to_r);
      default: mem_raddr = addr_r;
    endcase
    mem_we = (ctl.wr != WR_NONE);
    case (ctl.wr)
      WR_INIT: begin
        mem_waddr = addr_r;
        mem_wdata = addr_r;
      end
      WR_SWEEP: begin
        mem_waddr = AW'(addr_r - 1'b1);
        mem_wdata = (mem_rdata == second_r) ? first_r : mem_rdata;
      end
      default: begin
        mem_waddr = addr_r;
        mem_wdata = mem_rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= '0;
      count_r     <= '0;
      addr_r      <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        vcount_r <= cfg_if.vertex_count;
      end
      if (ctl.addr_inc) begin
        addr_r <= AW'(addr_r + 1'b1);
      end
      if (ctl.ld_item && in_fire) begin
        acc_r <= 1'b0;
      end
      if (ctl.cnt_clr) begin
        count_r <= '0;
      end else if (ctl.try_accept && !same) begin
        acc_r <= 1'b1;
        if (count_r != COUNT_MAX) begin
          count_r <= CNTW'(count_r + 1'b1);
        end
      end
      if (ctl.out_load && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_item && in_fire) begin
      from_r <= in_if.from_vertex;
      to_r   <= in_if.to_vertex;
      len_r  <= in_if.edge_length;
      last_r <= in_if.last_edge;
    end
    if (ctl.cap_first) begin
      first_r <= mem_rdata;
    end
    if (ctl.try_accept) begin
      second_r <= mem_rdata;
    end
    if (ctl.out_load && out_free) begin
      out_acc_r    <= acc_r;
      out_status_r <= bad ? STATUS_BAD : STATUS_OK;
      out_from_r   <= from_r;
      out_to_r     <= to_r;
      out_len_r    <= len_r;
      out_cnt_r    <= count_r;
      out_done_r   <= done;
      out_last_r   <= last_r;
    end
  end

  assign in_if.ready          = ctl.in_rdy;
  assign cfg_if.ready         = 1'b1;
  assign out_if.valid         = out_valid_r;
  assign out_if.accepted      = out_acc_r;
  assign out_if.status        = out_status_r;
  assign out_if.edge_from     = out_from_r;
  assign out_if.edge_to       = out_to_r;
  assign out_if.edge_weight   = out_len_r;
  assign out_if.tree_edges    = out_cnt_r;
  assign out_if.spanning_done = out_done_r;
  assign out_if.final_edge    = out_last_r;

`ifndef ASSERT_OFF
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> upc != UC_IDLE)
    else $error("sequencer stayed idle after taking a word");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.cnt_clr |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1))
    else $error("tree count moved by more than one");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (upc == UC_IDLE) |-> !mem_we)
    else $error("label write while idle");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(upc) == UC_EMIT)
    else $error("result raised outside emit step");
`endif

endmodule

// ===== sv/mstqf_label_mem.sv =====
module mstqf_label_mem import mstqf_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [LABEL_DEPTH];
  logic [AW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mstqf_useq.sv =====
module mstqf_useq import mstqf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  stat_t            st,
  output ctrl_t            ctl,
  output logic [UPC_W-1:0] upc
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic [UPC_W-1:0] upc_inc;

  assign ctl     = ucode(upc_r);
  assign upc     = upc_r;
  assign upc_inc = UPC_W'(upc_r + 1'b1);

  always_comb begin
    upc_nxt = upc_inc;
    case (ctl.cond)
      C_SEQ:      upc_nxt = upc_inc;
      C_GOTO:     upc_nxt = ctl.target;
      C_LOOP:     upc_nxt = st.addr_last ? ctl.target : upc_r;
      C_WAIT_IN:  upc_nxt = !st.in_valid ? upc_r : (st.new_graph ? ctl.target : upc_inc);
      C_BAD:      upc_nxt = st.bad ? ctl.target : upc_inc;
      C_SAME:     upc_nxt = st.same ? ctl.target : upc_inc;
      C_WAIT_OUT: upc_nxt = st.out_free ? ctl.target : upc_r;
      default:    upc_nxt = UC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UC_RST_INIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_wait_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == UC_IDLE && !st.in_valid) |=> upc_r == UC_IDLE)
    else $error("sequencer left idle without an input word");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == UC_EMIT && !st.out_free) |=> upc_r == UC_EMIT)
    else $error("result dropped while output slot busy");

  a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == UC_SWEEP && !st.addr_last) |=> upc_r == UC_SWEEP)
    else $error("relabel sweep ended early");
`endif

endmodule

// ===== tb/mst_edge_acceptor_quick_find_unit_tb.sv =====
module mst_edge_acceptor_quick_find_unit_tb import mstqf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int RANDOM_EDGES = 580;
  localparam int SETTLE_CYCLES = 2100;

  typedef struct packed {
    logic          new_graph;
    logic [VW-1:0] from_v;
    logic [VW-1:0] to_v;
    logic [WW-1:0] weight;
    logic          last;
  } edge_word_t;

  typedef struct packed {
    logic            accepted;
    logic            status;
    logic [VW-1:0]   from_v;
    logic [VW-1:0]   to_v;
    logic [WW-1:0]   weight;
    logic [CNTW-1:0] tree_edges;
    logic            spanning_done;
    logic            final_edge;
  } result_word_t;

  // mirrors the label table, tree count and vertex_count; queues expected words
  class forest_tracker;
    logic [VW-1:0]   labels [LABEL_DEPTH];
    logic [CNTW-1:0] tree_count;
    logic [VW-1:0]   vertex_count;
    result_word_t    pending_results[$];
    int              errors;

    function new();
      restart();
      vertex_count = '0;
      errors = 0;
    endfunction

    function void restart();
      foreach (labels[i]) labels[i] = VW'(i);
      tree_count = '0;
    endfunction

    function void note_edge(edge_word_t e);
      result_word_t  r;
      int            nv;
      logic [VW-1:0] first;
      logic [VW-1:0] second;
      logic          bad;
      if (e.new_graph) restart();
      nv = (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
      bad = (e.from_v == 0) || (int'(e.from_v) > nv) || (e.to_v == 0) || (int'(e.to_v) > nv);
      r = '0;
      r.status = bad ? STATUS_BAD : STATUS_OK;
      if (!bad) begin
        first = labels[e.from_v];
        second = labels[e.to_v];
        if (first != second) begin
          r.accepted = 1'b1;
          if (tree_count != COUNT_MAX) tree_count = tree_count + 1'b1;
          foreach (labels[i]) if (labels[i] == second) labels[i] = first;
        end
      end
      r.from_v = e.from_v;
      r.to_v = e.to_v;
      r.weight = e.weight;
      r.tree_edges = tree_count;
      r.spanning_done = (int'(tree_count) + 1 >= nv);
      r.final_edge = e.last;
      pending_results.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: from %0d to %0d", got.from_v, got.to_v);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      cmp_field("accepted", 32'(want.accepted), 32'(got.accepted));
      cmp_field("status", 32'(want.status), 32'(got.status));
      cmp_field("edge_from", 32'(want.from_v), 32'(got.from_v));
      cmp_field("edge_to", 32'(want.to_v), 32'(got.to_v));
      cmp_field("edge_weight", 32'(want.weight), 32'(got.weight));
      cmp_field("tree_edges", 32'(want.tree_edges), 32'(got.tree_edges));
      cmp_field("spanning_done", 32'(want.spanning_done), 32'(got.spanning_done));
      cmp_field("final_edge", 32'(want.final_edge), 32'(got.final_edge));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   gap_pct;
  int   stall_pct;

  mstqf_in_if  in_if();
  mstqf_out_if out_if();
  mstqf_cfg_if cfg_if();

  forest_tracker tracker = new();

  mst_edge_acceptor_quick_find_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    result_word_t got;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= stall_pct);
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
        got.accepted = out_if.accepted;
        got.status = out_if.status;
        got.from_v = out_if.edge_from;
        got.to_v = out_if.edge_to;
        got.weight = out_if.edge_weight;
        got.tree_edges = out_if.tree_edges;
        got.spanning_done = out_if.spanning_done;
        got.final_edge = out_if.final_edge;
        tracker.check_result(got);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the handshake
  task automatic push_edge(input edge_word_t e);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.new_graph = e.new_graph;
    in_if.from_vertex = e.from_v;
    in_if.to_vertex = e.to_v;
    in_if.edge_length = e.weight;
    in_if.last_edge = e.last;
    in_if.valid = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.note_edge(e);
    @(negedge clk);
  endtask

  task automatic send(input logic ng, input int f, input int t, input logic [WW-1:0] w,
                      input logic last);
    edge_word_t e;
    e.new_graph = ng;
    e.from_v = VW'(f);
    e.to_v = VW'(t);
    e.weight = w;
    e.last = last;
    push_edge(e);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [VW-1:0] v);
    drain();
    cfg_if.vertex_count = v;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    tracker.vertex_count = v;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  initial begin
    edge_word_t e;
    int         sent;
    int         g;
    int         pick;
    int         nv;
    int         n;
    int         split;
    longint     w;

    gap_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.new_graph = 1'b0;
    in_if.from_vertex = '0;
    in_if.to_vertex = '0;
    in_if.edge_length = '0;
    in_if.last_edge = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.vertex_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    write_vertex_count(VW'(5));
    send(1'b1, 1, 2, '0, 1'b0);
    send(1'b0, 2, 1, WW'(5), 1'b0);
    send(1'b0, 3, 3, WW'(6), 1'b0);
    send(1'b0, 0, 1, WW'(7), 1'b0);
    send(1'b0, 1, 6, WW'(8), 1'b0);
    send(1'b0, 1023, 2, WW'(9), 1'b0);
    send(1'b0, 3, 4, WW'(10), 1'b0);
    send(1'b0, 2, 4, WW'(11), 1'b0);
    send(1'b0, 5, 1, '1, 1'b1);
    send(1'b1, 0, 0, WW'(1), 1'b0);
    send(1'b0, 1, 2, WW'(2), 1'b1);
    write_vertex_count(VW'(0));
    send(1'b1, 1, 1, WW'(3), 1'b1);
    write_vertex_count(VW'(1));
    send(1'b1, 1, 1, WW'(4), 1'b1);
    write_vertex_count(VW'(1023));
    send(1'b1, 1, 1023, WW'(12), 1'b0);
    send(1'b0, 1023, 512, WW'(13), 1'b0);
    send(1'b0, 682, 341, WW'(14), 1'b0);
    // vertex_count shrinks within the graph
    write_vertex_count(VW'(3));
    send(1'b0, 2, 3, WW'(15), 1'b0);
    send(1'b0, 1023, 2, WW'(16), 1'b0);
    send(1'b0, 1, 3, 31'h5555_5555, 1'b1);

    sent = 0;
    g = 0;
    while (sent < RANDOM_EDGES) begin
      case (g % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 79; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 79; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      pick = $urandom_range(99);
      if (pick < 4) nv = 1023;
      else if (pick < 8) nv = $urandom_range(0, 1);
      else if (pick < 20) nv = $urandom_range(17, 80);
      else nv = $urandom_range(2, 16);
      write_vertex_count(VW'(nv));
      if (nv == 1023) n = $urandom_range(8, 20);
      else if (nv < 2) n = $urandom_range(1, 4);
      else begin
        n = nv - 1;
        if (n > 40) n = 40;
        n = n + $urandom_range(0, 8);
      end
      split = (nv != 1023 && $urandom_range(99) < 8) ? n / 2 : -1;
      w = $urandom_range(0, 32'h7FFF_0000);
      for (int k = 0; k < n; k++) begin
        if (k == split) write_vertex_count(VW'($urandom_range(0, nv + 4)));
        e.new_graph = (k == 0) ? ($urandom_range(99) >= 10) : ($urandom_range(99) < 2);
        e.last = (k == n - 1) ? ($urandom_range(99) >= 5) : ($urandom_range(99) < 2);
        w = w + $urandom_range(0, 4000);
        if (w > 64'h7FFF_FFFF) w = 64'h7FFF_FFFF;
        if ($urandom_range(99) < 8) begin
          e.from_v = VW'($urandom_range(0, 1023));
          e.to_v = VW'($urandom_range(0, 1023));
          e.weight = WW'($urandom);
        end else begin
          e.from_v = VW'($urandom_range(1, (nv > 1) ? nv : 1));
          e.to_v = VW'($urandom_range(1, (nv > 1) ? nv : 1));
          e.weight = WW'(w);
        end
        push_edge(e);
        sent++;
      end
      g++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
